@@ hw/rtl/tvi_pkg.sv @@
`default_nettype none
package tvi_pkg;

   localparam int TimeWidth = 48;
   localparam int VelWidth  = 32;
   localparam int MagWidth  = 33;
   localparam int ProdWidth = MagWidth + TimeWidth;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FEW      = 2'd1;
   localparam logic [1:0] STATUS_BEFORE   = 2'd2;
   localparam logic [1:0] STATUS_PAST_END = 2'd3;

   typedef struct packed {
      logic [1:0]                  mode;
      logic [TimeWidth-1:0]        sample_time;
      logic signed [VelWidth-1:0]  vel_x;
      logic signed [VelWidth-1:0]  vel_y;
      logic signed [VelWidth-1:0]  turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [VelWidth-1:0]  out_vel_x;
      logic signed [VelWidth-1:0]  out_vel_y;
      logic signed [VelWidth-1:0]  out_turn_rate;
      logic [1:0]                  status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_req;
      logic       clear;
      logic       append;
      logic       rd_first;
      logic       rd_last;
      logic       rd_scan;
      logic       rd_seg0;
      logic       rd_seg1;
      logic       cap_first;
      logic       cap_last;
      logic       cap_scan;
      logic       cap_seg0;
      logic       cap_seg1;
      logic       scan_restart;
      logic       mul_start;
      logic       mul_step;
      logic       div_start;
      logic       div_step;
      logic       lane_store;
      logic [1:0] lane;
      logic       set_status;
      logic [1:0] status;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic mode_append;
      logic mode_query;
      logic mode_clear;
      logic can_append;
      logic under_two;
      logic before_first;
      logic past_last;
      logic scan_le;
      logic scan_done;
      logic mul_done;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

@@ hw/rtl/tvi_ctrl.sv @@
`default_nettype none
module tvi_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire tvi_pkg::sts_type sts,
   output tvi_pkg::cmd_type      cmd
);
   import tvi_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_RDLAST = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_SCANRD = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_SEG0   = 4'd6;
   localparam logic [3:0] S_SEG1   = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;
   localparam logic [3:0] S_LANE   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] lane_ff, lane_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lane_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      lane_in  = lane_ff;
      cmd      = '0;
      cmd.lane = lane_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.rd_last  = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            // Last point time is on the read port now.
            cmd.cap_last = 1'b1;
            cmd.rd_first = 1'b1;
            if (sts.mode_clear) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end else if (sts.mode_append) begin
               state_in = S_RDLAST;
            end else if (sts.mode_query) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RDLAST: begin
            cmd.append = sts.can_append;
            state_in   = S_IDLE;
         end
         S_CHECK: begin
            cmd.cap_first = 1'b1;
            state_in      = S_SCANRD;
         end
         S_SCANRD: begin
            cmd.set_status = 1'b1;
            if (sts.under_two) begin
               cmd.status = STATUS_FEW;
               state_in   = S_RESP;
            end else if (sts.before_first) begin
               cmd.status = STATUS_BEFORE;
               state_in   = S_RESP;
            end else if (sts.past_last) begin
               cmd.status = STATUS_PAST_END;
               state_in   = S_RESP;
            end else begin
               cmd.status       = STATUS_OK;
               cmd.scan_restart = 1'b1;
               cmd.rd_scan      = 1'b1;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            // Point index+1 is on the read port; advance while it is still <= time.
            cmd.cap_scan = 1'b1;
            if (sts.scan_le && !sts.scan_done) begin
               cmd.rd_scan = 1'b1;
            end else begin
               cmd.rd_seg0 = 1'b1;
               state_in    = S_SEG0;
            end
         end
         S_SEG0: begin
            cmd.cap_seg0 = 1'b1;
            cmd.rd_seg1  = 1'b1;
            state_in     = S_SEG1;
         end
         S_SEG1: begin
            cmd.cap_seg1 = 1'b1;
            lane_in      = 2'd0;
            state_in     = S_LANE;
         end
         S_LANE: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.lane_store = 1'b1;
               if (lane_ff == 2'd2) begin
                  state_in = S_RESP;
               end else begin
                  lane_in  = lane_ff + 2'd1;
                  state_in = S_LANE;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/tvi_datapath.sv @@
`default_nettype none
module tvi_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tvi_pkg::req_type req_data,
   input  wire tvi_pkg::cmd_type cmd,
   output tvi_pkg::sts_type      sts,
   output tvi_pkg::rsp_type      rsp_data
);
   import tvi_pkg::*;

   localparam int IdxWidth = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CntWidth = $clog2(MAX_POINTS + 1);
   localparam int MulCnt   = $clog2(TimeWidth + 1);
   localparam int DivCnt   = $clog2(ProdWidth + 1);

   typedef struct packed {
      logic [TimeWidth-1:0]       t;
      logic signed [VelWidth-1:0] vx;
      logic signed [VelWidth-1:0] vy;
      logic signed [VelWidth-1:0] vz;
   } entry_type;

   entry_type mem [MAX_POINTS];
   entry_type rd_ff;

   req_type              req_ff;
   logic [CntWidth-1:0]  count_ff;
   logic [TimeWidth-1:0] first_t_ff, last_t_ff;
   logic [IdxWidth-1:0]  seg_ff;
   logic [CntWidth-1:0]  scan_ff;
   entry_type            p0_ff, p1_ff;
   logic [1:0]           status_ff;
   logic signed [VelWidth-1:0] res_ff [3];

   logic [IdxWidth-1:0] rd_addr;
   logic [CntWidth-1:0] last_idx;
   logic [CntWidth-1:0] scan_nxt;

   assign last_idx = count_ff - CntWidth'(1);
   assign scan_nxt = scan_ff + CntWidth'(1);

   // During the scan, scan_ff is the index of the point held in rd_ff.
   always_comb begin
      rd_addr = '0;
      if (cmd.rd_last) begin
         rd_addr = last_idx[IdxWidth-1:0];
      end else if (cmd.rd_first) begin
         rd_addr = '0;
      end else if (cmd.scan_restart) begin
         rd_addr = IdxWidth'(1);
      end else if (cmd.rd_scan) begin
         rd_addr = scan_nxt[IdxWidth-1:0];
      end else if (cmd.rd_seg0) begin
         rd_addr = seg_ff;
      end else if (cmd.rd_seg1) begin
         rd_addr = seg_ff + IdxWidth'(1);
      end
   end

   // On the load cycle the count is not yet known to be nonzero; reading
   // entry count-1 of an empty table is harmless since it is ignored.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[IdxWidth-1:0]] <= {req_ff.sample_time, req_ff.vel_x,
                                         req_ff.vel_y, req_ff.turn_rate};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.cap_last) last_t_ff <= rd_ff.t;
      if (cmd.cap_first) first_t_ff <= rd_ff.t;
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.scan_restart) begin
         seg_ff  <= '0;
         scan_ff <= CntWidth'(1);
      end else if (cmd.rd_scan) begin
         scan_ff <= scan_nxt;
      end
      if (cmd.cap_scan && rd_ff.t <= req_ff.sample_time) begin
         seg_ff <= seg_ff + IdxWidth'(1);
      end
      if (cmd.cap_seg0) p0_ff <= rd_ff;
      if (cmd.cap_seg1) p1_ff <= rd_ff;
   end

   // The scan stops once the next point lies beyond the query time; with
   // the range checks passed, a later point always does.
   assign sts.mode_clear   = (req_ff.mode == MODE_CLEAR);
   assign sts.mode_append  = (req_ff.mode == MODE_APPEND);
   assign sts.mode_query   = (req_ff.mode == MODE_QUERY);
   assign sts.can_append   = (count_ff < CntWidth'(MAX_POINTS)) &&
                             ((count_ff == '0) || (req_ff.sample_time >= last_t_ff));
   assign sts.under_two    = (count_ff < CntWidth'(2));
   assign sts.before_first = (req_ff.sample_time < first_t_ff);
   assign sts.past_last    = (req_ff.sample_time >= last_t_ff);
   assign sts.scan_le      = (rd_ff.t <= req_ff.sample_time);
   assign sts.scan_done    = (scan_ff >= last_idx);

   // Lane operands.
   logic signed [VelWidth-1:0] v0, v1;
   logic signed [MagWidth-1:0] diff;
   logic [MagWidth-1:0]        mag;
   logic [TimeWidth-1:0]       dt, span;

   always_comb begin
      case (cmd.lane)
         2'd0:    begin v0 = p0_ff.vx; v1 = p1_ff.vx; end
         2'd1:    begin v0 = p0_ff.vy; v1 = p1_ff.vy; end
         default: begin v0 = p0_ff.vz; v1 = p1_ff.vz; end
      endcase
      diff = MagWidth'(v1) - MagWidth'(v0);
      mag  = diff[MagWidth-1] ? MagWidth'(-diff) : MagWidth'(diff);
      dt   = req_ff.sample_time - p0_ff.t;
      span = p1_ff.t - p0_ff.t;
   end

   // Shift-add multiplier, one multiplier bit per cycle.
   logic [ProdWidth-1:0] prod_ff, mcand_ff;
   logic [TimeWidth-1:0] mplier_ff;
   logic [MulCnt-1:0]    mcnt_ff;
   logic                 neg_ff;

   assign sts.mul_done = (mcnt_ff == MulCnt'(TimeWidth - 1));

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         prod_ff   <= '0;
         mcand_ff  <= ProdWidth'(mag);
         mplier_ff <= dt;
         mcnt_ff   <= '0;
         neg_ff    <= diff[MagWidth-1];
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         mcnt_ff   <= mcnt_ff + MulCnt'(1);
      end
   end

   // Restoring divider, one quotient bit per cycle.
   logic [ProdWidth-1:0] dividend_ff, quo_ff;
   logic [TimeWidth:0]   rem_ff;
   logic [DivCnt-1:0]    dcnt_ff;
   logic [TimeWidth:0]   rem_sh;

   assign rem_sh       = {rem_ff[TimeWidth-1:0], dividend_ff[ProdWidth-1]};
   assign sts.div_done = (dcnt_ff == DivCnt'(ProdWidth));

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dividend_ff <= mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
         rem_ff      <= '0;
         quo_ff      <= '0;
         dcnt_ff     <= '0;
      end else if (cmd.div_step && !sts.div_done) begin
         dividend_ff <= dividend_ff << 1;
         dcnt_ff     <= dcnt_ff + DivCnt'(1);
         if (rem_sh >= {1'b0, span}) begin
            rem_ff <= rem_sh - {1'b0, span};
            quo_ff <= {quo_ff[ProdWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[ProdWidth-2:0], 1'b0};
         end
      end
   end

   logic [VelWidth-1:0] qlow;
   assign qlow = quo_ff[VelWidth-1:0];

   always_ff @(posedge clock) begin
      if (cmd.lane_store) begin
         res_ff[cmd.lane] <= (span == '0) ? v0 :
                             (neg_ff ? v0 - $signed(qlow) : v0 + $signed(qlow));
      end
   end

   always_comb begin
      rsp_data.status = status_ff;
      if (status_ff == STATUS_OK) begin
         rsp_data.out_vel_x     = res_ff[0];
         rsp_data.out_vel_y     = res_ff[1];
         rsp_data.out_turn_rate = res_ff[2];
      end else begin
         rsp_data.out_vel_x     = '0;
         rsp_data.out_vel_y     = '0;
         rsp_data.out_turn_rate = '0;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/trajectory_velocity_interpolator_top.sv @@
`default_nettype none
// Velocity point table with linear interpolation. A query runs range checks,
// then a linear segment search over the table points, then for each of the
// three velocities a shift-add multiply and a restoring divide on one shared
// unit. The table is one memory of MAX_POINTS entries with one write and one
// read port; entries are never cleared, only the point count is.
module trajectory_velocity_interpolator_top #(
   parameter int MAX_POINTS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tvi_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tvi_pkg::rsp_type      rsp_data
);
   import tvi_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tvi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tvi_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import tvi_pkg::*;

   localparam int TablePoints = 64;
   localparam int StallLimit  = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   trajectory_velocity_interpolator_top #(.MAX_POINTS(TablePoints)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow copy of the velocity table.
   logic [47:0]        pt_time [TablePoints];
   logic signed [31:0] pt_vx [TablePoints];
   logic signed [31:0] pt_vy [TablePoints];
   logic signed [31:0] pt_wz [TablePoints];
   int                 pt_count;

   rsp_type pending_rsp[$];
   int      mismatch_count;
   int      idle_cycles;
   int      sent_count;
   bit      hold_off;
   bit      timed_out;

   function automatic logic signed [31:0] blend(logic signed [31:0] v0,
                                                logic signed [31:0] v1,
                                                logic [47:0] dt, logic [47:0] span);
      logic signed [33:0] diff;
      logic [33:0]        mag;
      logic [81:0]        prod;
      logic [81:0]        quo;
      diff = 34'(v1) - 34'(v0);
      if (span == 0 || diff == 0) return v0;
      mag  = diff[33] ? 34'(-diff) : 34'(diff);
      prod = 82'(mag) * 82'(dt);
      quo  = prod / 82'(span);
      return diff[33] ? 32'(v0 - 34'(quo)) : 32'(v0 + 34'(quo));
   endfunction

   function automatic bit apply_word(req_type w, output rsp_type r);
      int seg;
      r = '0;
      case (w.mode)
         MODE_CLEAR: begin
            pt_count = 0;
            return 0;
         end
         MODE_APPEND: begin
            if (pt_count >= TablePoints) return 0;
            if (pt_count > 0 && w.sample_time < pt_time[pt_count-1]) return 0;
            pt_time[pt_count] = w.sample_time;
            pt_vx[pt_count]   = w.vel_x;
            pt_vy[pt_count]   = w.vel_y;
            pt_wz[pt_count]   = w.turn_rate;
            pt_count++;
            return 0;
         end
         MODE_QUERY: begin
            if (pt_count < 2) r.status = STATUS_FEW;
            else if (w.sample_time < pt_time[0]) r.status = STATUS_BEFORE;
            else if (w.sample_time >= pt_time[pt_count-1]) r.status = STATUS_PAST_END;
            else begin
               seg = 0;
               for (int i = 0; i + 1 < pt_count; i++)
                  if (pt_time[i] <= w.sample_time) seg = i;
               r.status = STATUS_OK;
               r.out_vel_x = blend(pt_vx[seg], pt_vx[seg+1],
                  w.sample_time - pt_time[seg], pt_time[seg+1] - pt_time[seg]);
               r.out_vel_y = blend(pt_vy[seg], pt_vy[seg+1],
                  w.sample_time - pt_time[seg], pt_time[seg+1] - pt_time[seg]);
               r.out_turn_rate = blend(pt_wz[seg], pt_wz[seg+1],
                  w.sample_time - pt_time[seg], pt_time[seg+1] - pt_time[seg]);
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
      return $urandom_range(0, 4);
   endfunction

   function automatic logic signed [31:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'($urandom_range(0, 200)) - 32'sd100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [47:0] rand_time();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Valid stays high from one word to the next when there is no gap.
   task automatic send_word(req_type w);
      rsp_type r;
      int      gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (apply_word(w, r)) pending_rsp.push_back(r);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_rsp.size() == 0);
   endtask

   function automatic req_type mk(logic [1:0] m, logic [47:0] t,
                                  logic signed [31:0] x = 0,
                                  logic signed [31:0] y = 0,
                                  logic signed [31:0] z = 0);
      req_type w;
      w.mode = m; w.sample_time = t; w.vel_x = x; w.vel_y = y; w.turn_rate = z;
      return w;
   endfunction

   // Build a table of nondecreasing times, then query across and around it.
   task automatic run_random_block(int n_points, int n_queries);
      logic [47:0] t;
      logic [47:0] step;
      logic [47:0] qt;
      send_word(mk(MODE_CLEAR, rand_time(), $urandom, $urandom, $urandom));
      t = $urandom_range(0, 3) == 0 ? 48'h0 : 48'($urandom_range(0, 100000));
      for (int i = 0; i < n_points; i++) begin
         case ($urandom_range(0, 5))
            0: step = 0;
            1: step = {16'($urandom), 32'($urandom)} >> $urandom_range(6, 47);
            2: step = {16'($urandom), 32'($urandom)} >> 8;
            default: step = $urandom_range(1, 5000);
         endcase
         if ($urandom_range(0, 15) == 0 && t > 0)
            send_word(mk(MODE_APPEND, t - 1, rand_vel(), rand_vel(), rand_vel()));
         t = (t + step < t) ? 48'hFFFF_FFFF_FFFF : t + step;
         send_word(mk(MODE_APPEND, t, rand_vel(), rand_vel(), rand_vel()));
      end
      for (int q = 0; q < n_queries; q++) begin
         case ($urandom_range(0, 9))
            0: qt = rand_time();
            1: qt = pt_count > 0 ? pt_time[pt_count-1] : 48'h0;
            2: qt = pt_count > 0 ? pt_time[0] : 48'h0;
            3: begin
               send_word(mk(2'd3, rand_time(), $urandom, $urandom, $urandom));
               qt = rand_time();
            end
            default: begin
               qt = pt_count > 1 ? pt_time[0] + 48'(({$urandom, $urandom} %
                  (64'(pt_time[pt_count-1] - pt_time[0]) + 1))) : rand_time();
            end
         endcase
         send_word(mk(MODE_QUERY, qt, $urandom, $urandom, $urandom));
      end
   endtask

   typedef struct {
      req_type w;
      bit      has_rsp;
      rsp_type r;
   } vec_row;

   vec_row directed[$];

   initial begin
      rsp_type z;
      z = '0;
      req_valid = 1'b0;
      req_data  = '0;
      pt_count  = 0;
      sent_count = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Expected values filled in only where obvious; others use the predictor.
      directed.push_back('{mk(MODE_QUERY, 48'h0), 1, '{0, 0, 0, STATUS_FEW}});
      directed.push_back('{mk(MODE_APPEND, 48'd1000, 32'sh7FFFFFFF, 32'sh80000000, 0),
                           0, z});
      directed.push_back('{mk(MODE_QUERY, 48'd1000), 1, '{0, 0, 0, STATUS_FEW}});
      directed.push_back('{mk(MODE_APPEND, 48'd2000, 32'sh80000000, 32'sh7FFFFFFF, -1),
                           0, z});
      directed.push_back('{mk(MODE_QUERY, 48'd999), 1, '{0, 0, 0, STATUS_BEFORE}});
      directed.push_back('{mk(MODE_QUERY, 48'd2000), 1, '{0, 0, 0, STATUS_PAST_END}});
      directed.push_back('{mk(MODE_QUERY, 48'hFFFF_FFFF_FFFF), 1,
                           '{0, 0, 0, STATUS_PAST_END}});
      directed.push_back('{mk(MODE_QUERY, 48'd1000), 1,
                           '{32'sh7FFFFFFF, 32'sh80000000, 0, STATUS_OK}});
      directed.push_back('{mk(MODE_QUERY, 48'd1500), 0, z});
      directed.push_back('{mk(MODE_QUERY, 48'd1999), 0, z});
      // Out-of-order append is dropped; unused mode is ignored.
      directed.push_back('{mk(MODE_APPEND, 48'd10, 5, 5, 5), 0, z});
      directed.push_back('{mk(2'd3, 48'hFFFF_FFFF_FFFF, -1, -1, -1), 0, z});
      directed.push_back('{mk(MODE_APPEND, 48'd2000, 7, 7, 7), 0, z});
      directed.push_back('{mk(MODE_APPEND, 48'hFFFF_FFFF_FFFF, -7, 32'sh7FFFFFFF, 3),
                           0, z});
      directed.push_back('{mk(MODE_QUERY, 48'd2000), 0, z});
      directed.push_back('{mk(MODE_QUERY, 48'hFFFF_FFFF_FFFE), 0, z});
      directed.push_back('{mk(MODE_CLEAR, 48'h0), 0, z});
      directed.push_back('{mk(MODE_QUERY, 48'd1500), 1, '{0, 0, 0, STATUS_FEW}});
      directed.push_back('{mk(MODE_APPEND, 48'h0, 1, 2, 3), 0, z});
      directed.push_back('{mk(MODE_APPEND, 48'h0, 4, 5, 6), 0, z});
      directed.push_back('{mk(MODE_QUERY, 48'h0), 1, '{0, 0, 0, STATUS_PAST_END}});

      foreach (directed[i]) begin
         send_word(directed[i].w);
         if (directed[i].has_rsp && pending_rsp.size() > 0)
            pending_rsp[$] = directed[i].r;
      end

      // Fill the table to capacity and push appends past it.
      send_word(mk(MODE_CLEAR, 48'h0));
      for (int i = 0; i < TablePoints + 3; i++)
         send_word(mk(MODE_APPEND, 48'(i * 100), rand_vel(), rand_vel(), rand_vel()));
      hold_off = 1'b1;
      for (int i = 0; i < 6; i++)
         send_word(mk(MODE_QUERY, 48'($urandom_range(0, TablePoints * 100))));
      // Quiet sender until all answers are back.
      drain_responses();

      while (sent_count < 1200) begin
         int np;
         int nq;
         np = $urandom_range(0, 7) == 0 ? $urandom_range(0, TablePoints)
                                        : $urandom_range(0, 8);
         nq = $urandom_range(2, 10);
         run_random_block(np, nq);
      end

      drain_responses();
      repeat (1000) @(posedge clock);
      if (mismatch_count == 0 && !timed_out)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Receiver: random stalls plus one long hold-off while the full-table queries are sent.
   initial begin
      int hold;
      rsp_ready = 1'b0;
      hold_off  = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         hold = gap_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.out_vel_x !== e.out_vel_x ||
                rsp_data.out_vel_y !== e.out_vel_y ||
                rsp_data.out_turn_rate !== e.out_turn_rate ||
                rsp_data.status !== e.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Mismatch: expected x=%0d y=%0d w=%0d st=%0d, ",
                            "got x=%0d y=%0d w=%0d st=%0d"},
                           e.out_vel_x, e.out_vel_y, e.out_turn_rate, e.status,
                           rsp_data.out_vel_x, rsp_data.out_vel_y,
                           rsp_data.out_turn_rate, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
`default_nettype wire
